// ===== rtl/v3au_pkg.sv =====
// ----------------------------------------------------------------------------
// v3au_pkg
// Shared types, opcodes and constants of the 3-D vector arithmetic unit.
// ----------------------------------------------------------------------------
package v3au_pkg;

  localparam int COORD_W = 32;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int WIDE_W  = 2 * COORD_W + 2;
  localparam int MODE_W  = 4;
  localparam int AXIS_W  = 2;
  localparam int ANGLE_W = 16;
  localparam int ATAN_N  = 30;

  localparam logic [MODE_W-1:0] MODE_ADD       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SUB       = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SCALE     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DOT       = 4'd3;
  localparam logic [MODE_W-1:0] MODE_CROSS     = 4'd4;
  localparam logic [MODE_W-1:0] MODE_NORM      = 4'd5;
  localparam logic [MODE_W-1:0] MODE_NORMALIZE = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SHIFT     = 4'd7;
  localparam logic [MODE_W-1:0] MODE_ROTATE    = 4'd8;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // CORDIC gain compensation, Q2.30
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] scalar_in;
    logic [AXIS_W-1:0]         axis;
    logic [ANGLE_W-1:0]        angle;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;
    logic signed [COORD_W-1:0] scalar_out;
    logic                      overflow;
    logic                      zero_length;
  } out_beat_t;

  // Work item carried down the pipeline
  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [AXIS_W-1:0]       axis;
    logic [ANGLE_W-1:0]      angle;
    logic [2:0][COORD_W-1:0] a;
    logic [2:0][COORD_W-1:0] r;
    logic [COORD_W-1:0]      s;
    logic                    ovf;
    logic                    zl;
    logic [PROD_W-1:0]       sq;
    logic [COORD_W-1:0]      root;
  } item_t;

  // Saturate to COORD_W bits; bit COORD_W of the result flags saturation.
  function automatic logic [COORD_W:0] sat_wide(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    logic [COORD_W:0]         res;
    hi = {{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    lo = {{(WIDE_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
    if (v > hi) begin
      res = {2'b10, {(COORD_W-1){1'b1}}};
    end else if (v < lo) begin
      res = {2'b11, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, v[COORD_W-1:0]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/v3au_front.sv =====
// ----------------------------------------------------------------------------
// v3au_front
// Two stages: shared multipliers, then rounding, sums and saturation.
// ----------------------------------------------------------------------------
module v3au_front import v3au_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  in_beat_t in_beat,
  output logic     valid,
  output item_t    item
);

  localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) << (FRAC_BITS - 1);

  logic signed [COORD_W-1:0] op_a [6];
  logic signed [COORD_W-1:0] op_b [6];
  logic signed [PROD_W-1:0]  prod [6];
  logic                      s1_valid;
  in_beat_t                  s1_beat;

  logic signed [COORD_W-1:0] av [3];
  logic signed [COORD_W-1:0] bv [3];
  logic signed [WIDE_W-1:0]  w_add [3];
  logic signed [WIDE_W-1:0]  w_sub [3];
  logic signed [WIDE_W-1:0]  w_scl [3];
  logic signed [WIDE_W-1:0]  w_crs [3];
  logic signed [WIDE_W-1:0]  w_sft [3];
  logic signed [WIDE_W-1:0]  w_dot;
  logic [COORD_W:0]          t_add [3];
  logic [COORD_W:0]          t_sub [3];
  logic [COORD_W:0]          t_scl [3];
  logic [COORD_W:0]          t_crs [3];
  logic [COORD_W:0]          t_sft [3];
  logic [COORD_W:0]          t_dot;
  item_t                     nxt;

  // operand select for the six multipliers
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      op_a[i] = '0;
      op_b[i] = '0;
    end
    case (in_beat.mode) inside
      MODE_SCALE: begin
        op_a[0] = in_beat.scalar_in; op_b[0] = in_beat.b_x;
        op_a[1] = in_beat.scalar_in; op_b[1] = in_beat.b_y;
        op_a[2] = in_beat.scalar_in; op_b[2] = in_beat.b_z;
      end
      MODE_DOT: begin
        op_a[0] = in_beat.a_x; op_b[0] = in_beat.b_x;
        op_a[1] = in_beat.a_y; op_b[1] = in_beat.b_y;
        op_a[2] = in_beat.a_z; op_b[2] = in_beat.b_z;
      end
      MODE_CROSS: begin
        op_a[0] = in_beat.a_y; op_b[0] = in_beat.b_z;
        op_a[1] = in_beat.a_z; op_b[1] = in_beat.b_x;
        op_a[2] = in_beat.a_x; op_b[2] = in_beat.b_y;
        op_a[3] = in_beat.a_z; op_b[3] = in_beat.b_y;
        op_a[4] = in_beat.a_x; op_b[4] = in_beat.b_z;
        op_a[5] = in_beat.a_y; op_b[5] = in_beat.b_x;
      end
      MODE_NORM, MODE_NORMALIZE: begin
        op_a[0] = in_beat.a_x; op_b[0] = in_beat.a_x;
        op_a[1] = in_beat.a_y; op_b[1] = in_beat.a_y;
        op_a[2] = in_beat.a_z; op_b[2] = in_beat.a_z;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_beat <= in_beat;
      for (int i = 0; i < 6; i++) begin
        prod[i] <= op_a[i] * op_b[i];
      end
    end
  end

  always_comb begin
    av[0] = s1_beat.a_x; av[1] = s1_beat.a_y; av[2] = s1_beat.a_z;
    bv[0] = s1_beat.b_x; bv[1] = s1_beat.b_y; bv[2] = s1_beat.b_z;
    for (int i = 0; i < 3; i++) begin
      w_add[i] = WIDE_W'(av[i]) + WIDE_W'(bv[i]);
      w_sub[i] = WIDE_W'(av[i]) - WIDE_W'(bv[i]);
      w_scl[i] = (WIDE_W'(prod[i]) + HALF) >>> FRAC_BITS;
      w_crs[i] = (WIDE_W'(prod[i]) - WIDE_W'(prod[i+3]) + HALF) >>> FRAC_BITS;
      w_sft[i] = WIDE_W'(av[i]) + WIDE_W'(s1_beat.scalar_in);
      t_add[i] = sat_wide(w_add[i]);
      t_sub[i] = sat_wide(w_sub[i]);
      t_scl[i] = sat_wide(w_scl[i]);
      t_crs[i] = sat_wide(w_crs[i]);
      t_sft[i] = sat_wide(w_sft[i]);
    end
    w_dot = (WIDE_W'(prod[0]) + WIDE_W'(prod[1]) + WIDE_W'(prod[2]) + HALF) >>> FRAC_BITS;
    t_dot = sat_wide(w_dot);
  end

  always_comb begin
    nxt       = '0;
    nxt.mode  = s1_beat.mode;
    nxt.axis  = s1_beat.axis;
    nxt.angle = s1_beat.angle;
    nxt.sq    = prod[0] + prod[1] + prod[2];
    for (int i = 0; i < 3; i++) begin
      nxt.a[i] = av[i];
    end
    case (s1_beat.mode) inside
      MODE_ADD: begin
        for (int i = 0; i < 3; i++) begin
          nxt.r[i] = t_add[i][COORD_W-1:0];
          nxt.ovf  = nxt.ovf | t_add[i][COORD_W];
        end
      end
      MODE_SUB: begin
        for (int i = 0; i < 3; i++) begin
          nxt.r[i] = t_sub[i][COORD_W-1:0];
          nxt.ovf  = nxt.ovf | t_sub[i][COORD_W];
        end
      end
      MODE_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          nxt.r[i] = t_scl[i][COORD_W-1:0];
          nxt.ovf  = nxt.ovf | t_scl[i][COORD_W];
        end
      end
      MODE_DOT: begin
        nxt.s   = t_dot[COORD_W-1:0];
        nxt.ovf = t_dot[COORD_W];
      end
      MODE_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          nxt.r[i] = t_crs[i][COORD_W-1:0];
          nxt.ovf  = nxt.ovf | t_crs[i][COORD_W];
        end
      end
      MODE_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (s1_beat.axis == AXIS_W'(i)) begin
            nxt.r[i] = t_sft[i][COORD_W-1:0];
            nxt.ovf  = nxt.ovf | t_sft[i][COORD_W];
          end else begin
            nxt.r[i] = av[i];
          end
        end
      end
      MODE_ROTATE: begin
        for (int i = 0; i < 3; i++) begin
          nxt.r[i] = av[i];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      valid    <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      valid    <= s1_valid;
    end
  end

endmodule

// ===== rtl/v3au_cordic.sv =====
// ----------------------------------------------------------------------------
// v3au_cordic
// Rotation pipeline: quarter-turn prestep, one CORDIC step per stage, gain.
// ----------------------------------------------------------------------------
module v3au_cordic import v3au_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  item_t item_in,
  output logic  valid,
  output item_t item_out
);

  localparam int CW = COORD_W + 3;
  localparam int MW = CW + 32;
  localparam int ZW = 32;
  localparam logic signed [MW-1:0]     GAIN_RND = MW'(1) << 29;
  localparam logic [ANGLE_W:0]          ANG_RND  = (ANGLE_W + 1)'(1) << (ANGLE_W - 3);
  localparam logic signed [ANGLE_W-2:0] Z_OFS    = (ANGLE_W - 1)'(1) << (ANGLE_W - 3);

  logic [ANGLE_W:0]          ang_off;
  logic [1:0]                quad;
  logic signed [ANGLE_W-2:0] zfrac;
  logic signed [CW-1:0]      pu;
  logic signed [CW-1:0]      pv;
  logic signed [CW-1:0]      u_in;
  logic signed [CW-1:0]      v_in;
  logic signed [ZW-1:0]      z_in;

  logic signed [CW-1:0] u [STEPS+1];
  logic signed [CW-1:0] v [STEPS+1];
  logic signed [ZW-1:0] z [STEPS+1];
  item_t                it [STEPS+2];
  logic [STEPS+2:0]     vld;
  logic signed [MW-1:0] mu;
  logic signed [MW-1:0] mv;
  logic signed [WIDE_W-1:0] wu;
  logic signed [WIDE_W-1:0] wv;
  logic [COORD_W:0]     tu;
  logic [COORD_W:0]     tv;
  item_t                nxt;

  // nearest quarter turn taken exactly, remainder to the CORDIC
  always_comb begin
    ang_off = {1'b0, item_in.angle} + ANG_RND;
    quad    = ang_off[ANGLE_W-1:ANGLE_W-2];
    zfrac   = $signed({1'b0, ang_off[ANGLE_W-3:0]}) - Z_OFS;
    z_in    = ZW'(zfrac) <<< (ZW - ANGLE_W);
    unique case (item_in.axis)
      AXIS_X: begin
        pu = CW'($signed(item_in.a[1]));
        pv = CW'($signed(item_in.a[2]));
      end
      AXIS_Y: begin
        pu = CW'($signed(item_in.a[2]));
        pv = CW'($signed(item_in.a[0]));
      end
      default: begin
        pu = CW'($signed(item_in.a[0]));
        pv = CW'($signed(item_in.a[1]));
      end
    endcase
    case (quad)
      2'd1:    begin u_in = -pv; v_in = pu;  end
      2'd2:    begin u_in = -pu; v_in = -pv; end
      2'd3:    begin u_in = pv;  v_in = -pu; end
      default: begin u_in = pu;  v_in = pv;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u[0]  <= u_in;
      v[0]  <= v_in;
      z[0]  <= z_in;
      it[0] <= item_in;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        it[k+1] <= it[k];
        if (z[k] >= 0) begin
          u[k+1] <= u[k] - (v[k] >>> k);
          v[k+1] <= v[k] + (u[k] >>> k);
          z[k+1] <= z[k] - $signed(ATAN_TURN[k]);
        end else begin
          u[k+1] <= u[k] + (v[k] >>> k);
          v[k+1] <= v[k] - (u[k] >>> k);
          z[k+1] <= z[k] + $signed(ATAN_TURN[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it[STEPS+1] <= it[STEPS];
      mu          <= MW'(u[STEPS]) * MW'(CORDIC_GAIN);
      mv          <= MW'(v[STEPS]) * MW'(CORDIC_GAIN);
    end
  end

  always_comb begin
    wu  = WIDE_W'((mu + GAIN_RND) >>> 30);
    wv  = WIDE_W'((mv + GAIN_RND) >>> 30);
    tu  = sat_wide(wu);
    tv  = sat_wide(wv);
    nxt = it[STEPS+1];
    if (it[STEPS+1].mode == MODE_ROTATE) begin
      unique case (it[STEPS+1].axis)
        AXIS_X: begin
          nxt.r[1] = tu[COORD_W-1:0];
          nxt.r[2] = tv[COORD_W-1:0];
          nxt.ovf  = tu[COORD_W] | tv[COORD_W];
        end
        AXIS_Y: begin
          nxt.r[2] = tu[COORD_W-1:0];
          nxt.r[0] = tv[COORD_W-1:0];
          nxt.ovf  = tu[COORD_W] | tv[COORD_W];
        end
        AXIS_Z: begin
          nxt.r[0] = tu[COORD_W-1:0];
          nxt.r[1] = tv[COORD_W-1:0];
          nxt.ovf  = tu[COORD_W] | tv[COORD_W];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_out <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS+1:0], in_valid};
    end
  end

  assign valid = vld[STEPS+2];

endmodule

// ===== rtl/v3au_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3au_sqrt
// Integer square root of the sum of squares, one result bit per stage.
// ----------------------------------------------------------------------------
module v3au_sqrt import v3au_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  item_t item_in,
  output logic  valid,
  output item_t item_out
);

  logic [PROD_W-1:0]  rem  [COORD_W];
  logic [PROD_W-1:0]  root [COORD_W];
  item_t              it   [COORD_W];
  logic [COORD_W-1:0] vld;

  for (genvar k = 0; k < COORD_W; k++) begin : g_stage
    localparam logic [PROD_W-1:0] BIT = PROD_W'(1) << (PROD_W - 2 - 2 * k);

    logic [PROD_W-1:0] rem_src;
    logic [PROD_W-1:0] root_src;
    item_t             it_src;
    logic [PROD_W:0]   trial;

    if (k == 0) begin : g_first
      assign rem_src  = item_in.sq;
      assign root_src = '0;
      assign it_src   = item_in;
    end else begin : g_next
      assign rem_src  = rem[k-1];
      assign root_src = root[k-1];
      assign it_src   = it[k-1];
    end

    assign trial = {1'b0, root_src} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (en) begin
        it[k] <= it_src;
        if ({1'b0, rem_src} >= trial) begin
          rem[k]  <= rem_src - trial[PROD_W-1:0];
          root[k] <= (root_src >> 1) + BIT;
        end else begin
          rem[k]  <= rem_src;
          root[k] <= root_src >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[COORD_W-2:0], in_valid};
    end
  end

  always_comb begin
    item_out      = it[COORD_W-1];
    item_out.root = root[COORD_W-1][COORD_W-1:0];
  end

  assign valid = vld[COORD_W-1];

endmodule

// ===== rtl/v3au_div.sv =====
// ----------------------------------------------------------------------------
// v3au_div
// Three restoring dividers for normalize, one quotient bit per stage.
// ----------------------------------------------------------------------------
module v3au_div import v3au_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  item_t item_in,
  output logic  valid,
  output item_t item_out
);

  // |a_i| <= norm, so the quotient never exceeds 2^FRAC_BITS
  localparam int DW = COORD_W + FRAC_BITS + 1;
  localparam int QW = FRAC_BITS + 1;

  logic [COORD_W-1:0]     mag    [3];
  logic [2:0][DW-1:0]     rem_in;
  logic [2:0][DW-1:0]     rem [QW+1];
  logic [2:0][QW-1:0]     quo [QW+1];
  item_t                  it  [QW+1];
  logic [QW:0]            vld;
  logic signed [WIDE_W-1:0] sv [3];
  logic [COORD_W:0]       tq [3];
  item_t                  nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]    = item_in.a[i][COORD_W-1] ? (~item_in.a[i] + 1'b1) : item_in.a[i];
      rem_in[i] = (DW'(mag[i]) << FRAC_BITS) + DW'(item_in.root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= rem_in;
      quo[0] <= '0;
      it[0]  <= item_in;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    logic [DW-1:0] dvs;
    assign dvs = DW'(it[j].root) << (FRAC_BITS - j);

    always_ff @(posedge clk) begin
      if (en) begin
        it[j+1] <= it[j];
        for (int i = 0; i < 3; i++) begin
          if (rem[j][i] >= dvs) begin
            rem[j+1][i] <= rem[j][i] - dvs;
            quo[j+1][i] <= {quo[j][i][QW-2:0], 1'b1};
          end else begin
            rem[j+1][i] <= rem[j][i];
            quo[j+1][i] <= {quo[j][i][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // finish norm and normalize; everything else passes as is
  always_comb begin
    nxt = it[QW];
    for (int i = 0; i < 3; i++) begin
      sv[i] = $signed(WIDE_W'(quo[QW][i]));
      if (it[QW].a[i][COORD_W-1]) begin
        sv[i] = -sv[i];
      end
      tq[i] = sat_wide(sv[i]);
    end
    if (it[QW].mode == MODE_NORM) begin
      if (it[QW].root[COORD_W-1]) begin
        nxt.s   = {1'b0, {(COORD_W-1){1'b1}}};
        nxt.ovf = 1'b1;
      end else begin
        nxt.s = it[QW].root;
      end
    end else if (it[QW].mode == MODE_NORMALIZE) begin
      if (it[QW].root == '0) begin
        nxt.zl = 1'b1;
        nxt.r  = '0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          nxt.r[i] = tq[i][COORD_W-1:0];
          nxt.ovf  = nxt.ovf | tq[i][COORD_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  assign item_out = nxt;
  assign valid    = vld[QW];

endmodule

// ===== rtl/vector3_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// Pipelined 3-D vector unit in signed Q16.16 with saturation and CORDIC.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; the pipeline advances whenever the output
//   register is empty or being taken.
// Depth is set by the CORDIC chain, the 32 root stages of the square root and
//   the FRAC_BITS+1 quotient stages of the normalize dividers.
// Reset clears the valid flags only; data registers are not reset.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit import v3au_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  localparam int NSTEP = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;

  logic  en;
  logic  f_valid;
  item_t f_item;
  logic  c_valid;
  item_t c_item;
  logic  q_valid;
  item_t q_item;
  logic  d_valid;
  item_t d_item;

  // One global advance: every stage moves together, bubbles included.
  // Hold everything while a finished beat waits in the output register.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Multiply, then round/sum/saturate the simple operations.
  v3au_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_beat  (in_beat),
    .valid    (f_valid),
    .item     (f_item)
  );

  // Rotation about the chosen axis; other modes ride through.
  v3au_cordic #(
    .STEPS (NSTEP)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .item_in  (f_item),
    .valid    (c_valid),
    .item_out (c_item)
  );

  // Floor square root of the sum of squares for norm and normalize.
  v3au_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_valid),
    .item_in  (c_item),
    .valid    (q_valid),
    .item_out (q_item)
  );

  // Normalize dividers, plus final norm saturation and zero-vector flag.
  v3au_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (q_valid),
    .item_in  (q_item),
    .valid    (d_valid),
    .item_out (d_item)
  );

  // Output register: advance with the pipe, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat.r_x         <= d_item.r[0];
      out_beat.r_y         <= d_item.r[1];
      out_beat.r_z         <= d_item.r[2];
      out_beat.scalar_out  <= d_item.s;
      out_beat.overflow    <= d_item.ovf;
      out_beat.zero_length <= d_item.zl;
    end
  end

endmodule

// ===== tb/vector3_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_tb
// Drives directed and random vector operations through the unit with random
// gaps and output stalls, and checks every result beat against a predictor
// written in fixed point.
// ----------------------------------------------------------------------------

// Ordered store of predicted result beats
class vec_scoreboard;
  v3au_pkg::out_beat_t pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // Note an accepted input beat: queue its predicted result
  function void note_input(v3au_pkg::out_beat_t expected);
    pending.push_back(expected);
  endfunction

  function void check_result(v3au_pkg::out_beat_t actual);
    v3au_pkg::out_beat_t expected;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result beat %h", $time, actual);
      errors++;
    end else begin
      expected = pending.pop_front();
      if (actual.r_x !== expected.r_x) begin
        $display("%0t: r_x expected %h actual %h", $time, expected.r_x, actual.r_x);
        errors++;
      end
      if (actual.r_y !== expected.r_y) begin
        $display("%0t: r_y expected %h actual %h", $time, expected.r_y, actual.r_y);
        errors++;
      end
      if (actual.r_z !== expected.r_z) begin
        $display("%0t: r_z expected %h actual %h", $time, expected.r_z, actual.r_z);
        errors++;
      end
      if (actual.scalar_out !== expected.scalar_out) begin
        $display("%0t: scalar_out expected %h actual %h", $time,
                 expected.scalar_out, actual.scalar_out);
        errors++;
      end
      if (actual.overflow !== expected.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time,
                 expected.overflow, actual.overflow);
        errors++;
      end
      if (actual.zero_length !== expected.zero_length) begin
        $display("%0t: zero_length expected %b actual %b", $time,
                 expected.zero_length, actual.zero_length);
        errors++;
      end
    end
  endfunction
endclass

module vector3_arithmetic_unit_tb;
  import v3au_pkg::*;

  localparam int FRAC       = 16;
  localparam int STEPS      = 16;
  localparam int LATENCY    = 72;
  localparam int N_RANDOM   = 1250;
  localparam int WATCHDOG   = 4000;
  localparam longint CMAX   = 64'sd2147483647;
  localparam longint CMIN   = -64'sd2147483648;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  vec_scoreboard board;
  bit  feeding_done;
  bit  hold_off;       // long receiver hold-off in progress
  bit  quiet;          // stretch with no idling on either side
  int  idle_cycles;

  vector3_arithmetic_unit #(.FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  // Floor shift right that does not depend on the simulator's >>> of longint
  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >> s;
    return -64'sd1 - ((-64'sd1 - v) >> s);
  endfunction

  // Clamp to 32 bits and raise the overflow flag on clamping
  function automatic longint clamp(longint v, ref bit ovf);
    if (v > CMAX) begin
      ovf = 1'b1;
      return CMAX;
    end
    if (v < CMIN) begin
      ovf = 1'b1;
      return CMIN;
    end
    return v;
  endfunction

  // Sum of exact products, divided by 2^FRAC with rounding half up
  function automatic longint round_sum(longint p0, longint p1, longint p2);
    longint q;
    longint rem;
    longint parts[3];
    parts = '{p0, p1, p2};
    q = 0;
    rem = 0;
    foreach (parts[i]) begin
      q += floor_shr(parts[i], FRAC);
      rem += parts[i] - (floor_shr(parts[i], FRAC) <<< FRAC);
    end
    return q + floor_shr(rem + (64'sd1 <<< (FRAC - 1)), FRAC);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] sq);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv != 0) begin
      if (sq >= root + bitv) begin
        sq = sq - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Rotate the pair (u, v) counterclockwise by a binary angle
  function automatic void cordic_turn(ref longint u, ref longint v, input logic [15:0] ang);
    logic [16:0] biased;
    int     quarter;
    longint z;
    longint du;
    longint dv;
    longint t;
    biased = {1'b0, ang} + 17'h2000;
    quarter = int'(biased[15:14]);
    z = (longint'(biased[13:0]) - 64'sd8192) * 64'sd65536;
    // coarse step: exact quarter turns
    for (int k = 0; k < quarter; k++) begin
      t = u;
      u = -v;
      v = t;
    end
    for (int i = 0; i < STEPS; i++) begin
      du = floor_shr(v, i);
      dv = floor_shr(u, i);
      if (z >= 0) begin
        u -= du;
        v += dv;
        z -= longint'(ATAN_TURN[i]);
      end else begin
        u += du;
        v -= dv;
        z += longint'(ATAN_TURN[i]);
      end
    end
    u = floor_shr(u * longint'(CORDIC_GAIN) + (64'sd1 <<< 29), 30);
    v = floor_shr(v * longint'(CORDIC_GAIN) + (64'sd1 <<< 29), 30);
  endfunction

  function automatic out_beat_t predict_vector_op(in_beat_t x);
    out_beat_t   res;
    longint      a[3];
    longint      b[3];
    longint      r[3];
    longint      s;
    longint      sc;
    logic [63:0] sq;
    logic [63:0] n;
    logic [63:0] qv;
    bit          ovf;
    bit          zl;
    int          j;
    int          k;
    a = '{longint'(x.a_x), longint'(x.a_y), longint'(x.a_z)};
    b = '{longint'(x.b_x), longint'(x.b_y), longint'(x.b_z)};
    r = '{0, 0, 0};
    s = 0;
    sc = longint'(x.scalar_in);
    ovf = 1'b0;
    zl = 1'b0;
    case (x.mode)
      MODE_ADD: begin
        for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + b[i], ovf);
      end
      MODE_SUB: begin
        for (int i = 0; i < 3; i++) r[i] = clamp(a[i] - b[i], ovf);
      end
      MODE_SCALE: begin
        for (int i = 0; i < 3; i++) r[i] = clamp(round_sum(sc * b[i], 0, 0), ovf);
      end
      MODE_DOT: begin
        s = clamp(round_sum(a[0] * b[0], a[1] * b[1], a[2] * b[2]), ovf);
      end
      MODE_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          r[i] = clamp(round_sum(a[j] * b[k], -(a[k] * b[j]), 0), ovf);
        end
      end
      MODE_NORM, MODE_NORMALIZE: begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq += magnitude(a[i]) * magnitude(a[i]);
        n = int_sqrt(sq);
        if (x.mode == MODE_NORM) begin
          if (n > 64'(CMAX)) s = clamp(CMAX + 1, ovf);
          else s = longint'(n);
        end else if (n == 0) begin
          zl = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            qv = ((magnitude(a[i]) << FRAC) + n / 2) / n;
            r[i] = clamp((a[i] < 0) ? -longint'(qv) : longint'(qv), ovf);
          end
        end
      end
      MODE_SHIFT: begin
        r = a;
        if (x.axis != 2'd3) r[x.axis] = clamp(a[x.axis] + sc, ovf);
      end
      MODE_ROTATE: begin
        r = a;
        case (x.axis)
          AXIS_X:  cordic_turn(r[1], r[2], x.angle);
          AXIS_Y:  cordic_turn(r[2], r[0], x.angle);
          AXIS_Z:  cordic_turn(r[0], r[1], x.angle);
          default: ;
        endcase
        for (int i = 0; i < 3; i++) r[i] = clamp(r[i], ovf);
      end
      default: ;
    endcase
    res.r_x = r[0][31:0];
    res.r_y = r[1][31:0];
    res.r_z = r[2][31:0];
    res.scalar_out = s[31:0];
    res.overflow = ovf;
    res.zero_length = zl;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  // Coordinate with mostly moderate magnitudes, sometimes extremes or full range
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2, 3:    return $urandom();
      4:       return 32'h0;
      default: return 32'(signed'($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF);
    endcase
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t x;
    x.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
    x.a_x = pick_coord();
    x.a_y = pick_coord();
    x.a_z = pick_coord();
    x.b_x = pick_coord();
    x.b_y = pick_coord();
    x.b_z = pick_coord();
    x.scalar_in = pick_coord();
    x.axis = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    x.angle = 16'($urandom());
    return x;
  endfunction

  // Offer one beat, idling first at random; hold it until accepted
  task automatic send_beat(in_beat_t x);
    if (!quiet && !hold_off) begin
      while ($urandom_range(0, 99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_beat <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(predict_vector_op(x));
  endtask

  function automatic in_beat_t make_beat(logic [3:0] m, logic [31:0] ax, logic [31:0] ay,
                                         logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                                         logic [31:0] bz, logic [31:0] sc, logic [1:0] ax_sel,
                                         logic [15:0] ang);
    in_beat_t x;
    x = '{m, ax, ay, az, bx, by, bz, sc, ax_sel, ang};
    return x;
  endfunction

  initial begin
    in_beat_t x;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_beat = '0;
    feeding_done = 1'b0;
    quiet = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every operation, extremes and special cases
    send_beat(make_beat(MODE_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                        32'h00000001, 32'hFFFFFFFF, 32'h00020000, 0, AXIS_X, 0));
    send_beat(make_beat(MODE_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h1,
                        32'h00000001, 32'hFFFFFFFF, 32'h1, 0, AXIS_X, 0));
    send_beat(make_beat(MODE_SCALE, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h00008000,
                        32'h00018000, AXIS_X, 0));
    send_beat(make_beat(MODE_SCALE, 0, 0, 0, 32'h00000001, 32'hFFFFFFFF, 32'h3,
                        32'h00008000, AXIS_X, 0));
    send_beat(make_beat(MODE_DOT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, AXIS_X, 0));
    send_beat(make_beat(MODE_DOT, 32'h80000000, 32'h00010000, 32'h1,
                        32'h7FFFFFFF, 32'h00020000, 32'h00008000, 0, AXIS_X, 0));
    send_beat(make_beat(MODE_CROSS, 32'h00010000, 0, 0, 0, 32'h00010000, 0, 0, AXIS_X, 0));
    send_beat(make_beat(MODE_CROSS, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                        32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0, AXIS_X, 0));
    send_beat(make_beat(MODE_NORM, 32'h80000000, 32'h80000000, 32'h80000000,
                        0, 0, 0, 0, AXIS_X, 0));
    send_beat(make_beat(MODE_NORM, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0, AXIS_X, 0));
    send_beat(make_beat(MODE_NORMALIZE, 0, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    send_beat(make_beat(MODE_NORMALIZE, 32'h1, 0, 0, 0, 0, 0, 0, AXIS_X, 0));
    send_beat(make_beat(MODE_NORMALIZE, 32'h80000000, 32'h7FFFFFFF, 32'h1,
                        0, 0, 0, 0, AXIS_X, 0));
    send_beat(make_beat(MODE_SHIFT, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 32'h1, AXIS_X, 0));
    send_beat(make_beat(MODE_SHIFT, 0, 32'h80000000, 0, 0, 0, 0, 32'hFFFFFFFF, AXIS_Y, 0));
    send_beat(make_beat(MODE_SHIFT, 0, 0, 32'h5, 0, 0, 0, 32'h80000000, AXIS_Z, 0));
    send_beat(make_beat(MODE_SHIFT, 32'h5, 32'h6, 32'h7, 0, 0, 0, 32'h1234, 2'd3, 0));
    send_beat(make_beat(MODE_ROTATE, 0, 32'h00010000, 0, 0, 0, 0, 0, AXIS_X, 16'h4000));
    send_beat(make_beat(MODE_ROTATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        0, 0, 0, 0, AXIS_Y, 16'h2000));
    send_beat(make_beat(MODE_ROTATE, 32'h80000000, 32'h80000000, 32'h1,
                        0, 0, 0, 0, AXIS_Z, 16'hFFFF));
    send_beat(make_beat(MODE_ROTATE, 32'h5, 32'h6, 32'h7, 0, 0, 0, 0, 2'd3, 16'h1000));
    send_beat(make_beat(4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                        32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 2'd3, 16'hFFFF));
    send_beat(make_beat(4'd9, 32'h1, 0, 0, 0, 0, 0, 0, AXIS_X, 0));

    // random: a stretch with no idling in the middle
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 400 && n < 600);
      x = random_beat();
      send_beat(x);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    feeding_done = 1'b1;
  end

  // ---------------------------------------------------------------- receiver
  // Random stalls, plus one long hold-off while the sender keeps offering
  initial begin
    int beats_seen;
    out_stall = 1'b1;
    hold_off = 1'b0;
    beats_seen = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) beats_seen++;
      if (beats_seen == 300 && !hold_off) begin
        hold_off = 1'b1;
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
        beats_seen++;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 26);
      end
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_beat);
  end

  // ---------------------------------------------------------------- end and watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (feeding_done);
    while (board.pending.size() != 0 && idle_cycles < WATCHDOG) @(posedge clk);
    if (idle_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
    end else begin
      repeat (LATENCY + 20) @(posedge clk);
      if (board.errors == 0 && board.pending.size() == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("SCOREBOARD MISMATCH");
      end
    end
    $finish;
  end

  // Trip the run if traffic stops before all stimulus is in
  initial begin
    wait (idle_cycles >= WATCHDOG && !feeding_done);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/v3au_pkg.sv
rtl/v3au_front.sv
rtl/v3au_cordic.sv
rtl/v3au_sqrt.sv
rtl/v3au_div.sv
rtl/vector3_arithmetic_unit.sv
tb/vector3_arithmetic_unit_tb.sv
